/* rtl/rvr_pkg.sv */
package rvr_pkg;

  // field widths
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 14;

  // rotor part products: 16 x 16 signed
  localparam int PROD_W = 2 * DATA_W;
  // matrix entry: signed sum of four squares or a doubled sum or difference of products
  localparam int MAT_W  = PROD_W + 2;
  // matrix entry times vector component
  localparam int TERM_W = MAT_W + DATA_W;
  // three terms plus rounding offset
  localparam int SUM_W  = TERM_W + 2;

  localparam int RND_SHIFT = 2 * FRAC_BITS;
  localparam int RES_W     = SUM_W - RND_SHIFT;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (RND_SHIFT - 1));
  localparam logic signed [RES_W-1:0] SAT_HI   = RES_W'((64'sd1 <<< (DATA_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO   = RES_W'(-(64'sd1 <<< (DATA_W - 1)));

  localparam int LANES = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [MAT_W-1:0]  mat_t;
  typedef logic signed [TERM_W-1:0] term_t;

  typedef data_t vec3_t [LANES];
  typedef mat_t  row_t  [LANES];
  typedef row_t  mat3_t [LANES];

  // pipeline stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

/* rtl/rvr_if.sv */
interface rvr_in_if import rvr_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t vec_x;
  data_t vec_y;
  data_t vec_z;
  data_t rot_s;
  data_t rot_b12;
  data_t rot_b31;
  data_t rot_b23;

  modport source (
    output valid, vec_x, vec_y, vec_z, rot_s, rot_b12, rot_b31, rot_b23,
    input  ready
  );
  modport sink (
    input  valid, vec_x, vec_y, vec_z, rot_s, rot_b12, rot_b31, rot_b23,
    output ready
  );
endinterface

interface rvr_out_if import rvr_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t out_x;
  data_t out_y;
  data_t out_z;
  logic  clipped;

  modport source (
    output valid, out_x, out_y, out_z, clipped,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, clipped,
    output ready
  );
endinterface

/* rtl/rvr_rotor.sv */
module rvr_rotor import rvr_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  data_t    rot_s_i,
  input  data_t    rot_b12_i,
  input  data_t    rot_b31_i,
  input  data_t    rot_b23_i,
  output mat3_t    mat_o
);

  // stage 1: the ten distinct part products
  prod_t ss_q, aa_q, bb_q, cc_q;
  prod_t sa_q, sb_q, sc_q;
  prod_t ab_q, ac_q, bc_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      ss_q <= PROD_W'(rot_s_i)   * PROD_W'(rot_s_i);
      aa_q <= PROD_W'(rot_b12_i) * PROD_W'(rot_b12_i);
      bb_q <= PROD_W'(rot_b31_i) * PROD_W'(rot_b31_i);
      cc_q <= PROD_W'(rot_b23_i) * PROD_W'(rot_b23_i);
      sa_q <= PROD_W'(rot_s_i)   * PROD_W'(rot_b12_i);
      sb_q <= PROD_W'(rot_s_i)   * PROD_W'(rot_b31_i);
      sc_q <= PROD_W'(rot_s_i)   * PROD_W'(rot_b23_i);
      ab_q <= PROD_W'(rot_b12_i) * PROD_W'(rot_b31_i);
      ac_q <= PROD_W'(rot_b12_i) * PROD_W'(rot_b23_i);
      bc_q <= PROD_W'(rot_b31_i) * PROD_W'(rot_b23_i);
    end
  end

  // stage 2: matrix entries
  mat_t ss, aa, bb, cc, sa, sb, sc, ab, ac, bc;
  mat3_t mat_d, mat_q;

  always_comb begin
    ss = MAT_W'(ss_q);
    aa = MAT_W'(aa_q);
    bb = MAT_W'(bb_q);
    cc = MAT_W'(cc_q);
    sa = MAT_W'(sa_q);
    sb = MAT_W'(sb_q);
    sc = MAT_W'(sc_q);
    ab = MAT_W'(ab_q);
    ac = MAT_W'(ac_q);
    bc = MAT_W'(bc_q);

    mat_d[0][0] = ss - aa - bb + cc;
    mat_d[0][1] = (bc - sa) <<< 1;
    mat_d[0][2] = (sb + ac) <<< 1;
    mat_d[1][0] = (sa + bc) <<< 1;
    mat_d[1][1] = ss - aa + bb - cc;
    mat_d[1][2] = (ab - sc) <<< 1;
    mat_d[2][0] = (ac - sb) <<< 1;
    mat_d[2][1] = (sc + ab) <<< 1;
    mat_d[2][2] = ss + aa - bb - cc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

/* rtl/rvr_lane.sv */
module rvr_lane import rvr_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  row_t     row_i,
  input  vec3_t    vec_i,
  output data_t    res_o,
  output logic     clip_o
);

  // stage 3: row times vector, one product per column
  term_t term_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int i = 0; i < LANES; i++) begin
        term_q[i] <= TERM_W'(row_i[i]) * TERM_W'(vec_i[i]);
      end
    end
  end

  // stage 4: exact sum, round half up, saturate
  logic signed [SUM_W-1:0] sum;
  logic signed [RES_W-1:0] rnd;
  data_t                   res_d, res_q;
  logic                    clip_d, clip_q;

  always_comb begin
    sum = SUM_W'(term_q[0]) + SUM_W'(term_q[1]) + SUM_W'(term_q[2]) + RND_HALF;
    rnd = RES_W'(sum >>> RND_SHIFT);
    if (rnd > SAT_HI) begin
      res_d  = DATA_W'(SAT_HI);
      clip_d = 1'b1;
    end else if (rnd < SAT_LO) begin
      res_d  = DATA_W'(SAT_LO);
      clip_d = 1'b1;
    end else begin
      res_d  = rnd[DATA_W-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

/* rtl/rotor_vector_rotation.sv */
// An accepted input transaction passes the s1, s2, s3 and s4 registers before its result is on out_if.
// Throughput: one transaction per cycle, sustained, while out_if takes results.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only; the block
// then accepts at once. Data registers are not reset.
module rotor_vector_rotation import rvr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rvr_in_if.sink    in_if,
  rvr_out_if.source out_if
);

  // Pipeline:
  //   s1  ten rotor part products (16x16), vector captured
  //   s2  nine matrix entries (squares and doubled cross products)
  //   s3  three lanes, one per result row, each forming matrix row * vector
  //   s4  per-lane sum, round to nearest (ties up), saturate -> output register
  // The merge of the lanes is the OR of their saturation flags.
  //
  // Flow control: each stage loads when it is empty or when the stage after it
  // loads, so bubbles collapse and a stalled output only holds back the stages
  // that are full behind it.

  logic [4:1] vld_q, vld_d;
  pipe_en_t   en;

  always_comb begin
    en.s4 = ~vld_q[4] | out_if.ready;
    en.s3 = ~vld_q[3] | en.s4;
    en.s2 = ~vld_q[2] | en.s3;
    en.s1 = ~vld_q[1] | en.s2;
  end

  always_comb begin
    vld_d = vld_q;
    if (en.s1) vld_d[1] = in_if.valid;
    if (en.s2) vld_d[2] = vld_q[1];
    if (en.s3) vld_d[3] = vld_q[2];
    if (en.s4) vld_d[4] = vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_if.ready = en.s1;

  // vector travels alongside the rotor stages
  vec3_t vec1_q, vec2_q;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      vec1_q[0] <= in_if.vec_x;
      vec1_q[1] <= in_if.vec_y;
      vec1_q[2] <= in_if.vec_z;
    end
    if (en.s2) begin
      vec2_q <= vec1_q;
    end
  end

  mat3_t mat;

  rvr_rotor u_rotor (
    .clk_i     (clk_i),
    .en_i      (en),
    .rot_s_i   (in_if.rot_s),
    .rot_b12_i (in_if.rot_b12),
    .rot_b31_i (in_if.rot_b31),
    .rot_b23_i (in_if.rot_b23),
    .mat_o     (mat)
  );

  data_t res  [LANES];
  logic  clip [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rvr_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .row_i  (mat[g]),
      .vec_i  (vec2_q),
      .res_o  (res[g]),
      .clip_o (clip[g])
    );
  end

  // merge
  assign out_if.valid   = vld_q[4];
  assign out_if.out_x   = res[0];
  assign out_if.out_y   = res[1];
  assign out_if.out_z   = res[2];
  assign out_if.clipped = clip[0] | clip[1] | clip[2];

endmodule

/* tb/rotor_vector_rotation_test.sv */
`timescale 1ns / 1ps

module rotor_vector_rotation_test;
  import rvr_pkg::*;

  // One input transaction: vector plus rotor (Q1.14 parts).
  typedef struct packed {
    data_t vec_x;
    data_t vec_y;
    data_t vec_z;
    data_t rot_s;
    data_t rot_b12;
    data_t rot_b31;
    data_t rot_b23;
  } rot_job_t;

  // One output transaction.
  typedef struct packed {
    data_t out_x;
    data_t out_y;
    data_t out_z;
    logic  clipped;
  } rot_res_t;

  // Directed row: stimulus plus, where obvious, the result typed in by hand.
  typedef struct packed {
    rot_job_t job;
    bit       typed;
    rot_res_t res;
  } vector_case_t;

  // Flavors of random rotation jobs.
  typedef enum int {
    MIX_FULL,
    MIX_UNIT,
    MIX_CORNER,
    MIX_AXIS,
    MIX_SMALL_VEC
  } job_mix_e;

  localparam int     DIRECTED_ROWS = 22;
  localparam int     RANDOM_JOBS   = 1350;
  localparam int     MAX_WAIT      = 15;
  localparam int     DRAIN_CYCLES  = 16;
  localparam int     PRINT_CAP     = 50;
  localparam longint LANE_MAX      = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint LANE_MIN      = -LANE_MAX - 1;
  localparam int     UNIT_BOUND    = 11585;  // ~ 1/sqrt(2) in Q1.14

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rvr_in_if  in_if ();
  rvr_out_if out_if ();

  rotor_vector_rotation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rot_res_t     pending_rotations [$];
  int           mismatch_count = 0;
  bit           source_calm    = 1'b0;
  bit           sink_calm      = 1'b0;
  vector_case_t directed_cases [DIRECTED_ROWS];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Round half up at 2*FRAC_BITS, then clamp to the lane width.
  function automatic bit clamp_lane(input longint acc, output data_t lane);
    longint r;
    r = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > LANE_MAX) begin
      lane = data_t'(LANE_MAX);
      return 1'b1;
    end
    if (r < LANE_MIN) begin
      lane = data_t'(LANE_MIN);
      return 1'b1;
    end
    lane = data_t'(r);
    return 1'b0;
  endfunction

  // Build the rotation matrix from the rotor at full precision, then apply it.
  function automatic rot_res_t predict_rotation(input rot_job_t j);
    longint   s, a, b, c;
    longint   ss, aa, bb, cc, sa, sb, sc, ab, ac, bc;
    longint   m [3][3];
    longint   v [3];
    longint   acc;
    data_t    lane [3];
    bit       clip;
    rot_res_t r;
    s = longint'(j.rot_s);
    a = longint'(j.rot_b12);
    b = longint'(j.rot_b31);
    c = longint'(j.rot_b23);
    v[0] = longint'(j.vec_x);
    v[1] = longint'(j.vec_y);
    v[2] = longint'(j.vec_z);
    ss = s * s;  aa = a * a;  bb = b * b;  cc = c * c;
    sa = s * a;  sb = s * b;  sc = s * c;
    ab = a * b;  ac = a * c;  bc = b * c;
    m[0][0] = ss - aa - bb + cc;
    m[0][1] = 2 * (bc - sa);
    m[0][2] = 2 * (sb + ac);
    m[1][0] = 2 * (sa + bc);
    m[1][1] = ss - aa + bb - cc;
    m[1][2] = 2 * (ab - sc);
    m[2][0] = 2 * (ac - sb);
    m[2][1] = 2 * (sc + ab);
    m[2][2] = ss + aa - bb - cc;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      clip |= clamp_lane(acc, lane[i]);
    end
    r.out_x   = lane[0];
    r.out_y   = lane[1];
    r.out_z   = lane[2];
    r.clipped = clip;
    return r;
  endfunction

  function automatic vector_case_t make_case(input int x, y, z, s, a, b, c,
                                             input bit typed,
                                             input int ox, oy, oz,
                                             input bit clip);
    vector_case_t t;
    t.job.vec_x   = data_t'(x);
    t.job.vec_y   = data_t'(y);
    t.job.vec_z   = data_t'(z);
    t.job.rot_s   = data_t'(s);
    t.job.rot_b12 = data_t'(a);
    t.job.rot_b31 = data_t'(b);
    t.job.rot_b23 = data_t'(c);
    t.typed       = typed;
    t.res.out_x   = data_t'(ox);
    t.res.out_y   = data_t'(oy);
    t.res.out_z   = data_t'(oz);
    t.res.clipped = clip;
    return t;
  endfunction

  function automatic data_t corner_value();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      5: return 16'sh4000;
      default: return 16'shC000;
    endcase
  endfunction

  function automatic data_t bounded_value(input int bound);
    return data_t'(int'($urandom_range(0, 2 * bound)) - bound);
  endfunction

  function automatic rot_job_t random_job();
    rot_job_t j;
    job_mix_e mix;
    int       pick;
    pick = $urandom_range(0, 9);
    mix  = (pick < 4) ? MIX_FULL : (pick < 7) ? MIX_UNIT : (pick < 8) ? MIX_CORNER :
           (pick < 9) ? MIX_AXIS : MIX_SMALL_VEC;
    j = rot_job_t'({$urandom, $urandom, $urandom, $urandom});
    case (mix)
      MIX_UNIT: begin
        // rotor with norm at most ~1.4, the realistic neighborhood
        j.rot_s   = bounded_value(UNIT_BOUND);
        j.rot_b12 = bounded_value(UNIT_BOUND);
        j.rot_b31 = bounded_value(UNIT_BOUND);
        j.rot_b23 = bounded_value(UNIT_BOUND);
      end
      MIX_CORNER: begin
        j.vec_x   = corner_value();
        j.vec_y   = corner_value();
        j.vec_z   = corner_value();
        j.rot_s   = corner_value();
        j.rot_b12 = corner_value();
        j.rot_b31 = corner_value();
        j.rot_b23 = corner_value();
      end
      MIX_AXIS: begin
        // one part at +-1.0, the rest zero: exact half-turns or identity
        j.rot_s   = '0;
        j.rot_b12 = '0;
        j.rot_b31 = '0;
        j.rot_b23 = '0;
        case ($urandom_range(0, 3))
          0: j.rot_s   = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
          1: j.rot_b12 = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
          2: j.rot_b31 = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
          default: j.rot_b23 = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
        endcase
      end
      MIX_SMALL_VEC: begin
        // small vectors stress the rounding of fractional results
        j.vec_x   = bounded_value(8);
        j.vec_y   = bounded_value(8);
        j.vec_z   = bounded_value(8);
        j.rot_s   = bounded_value(UNIT_BOUND);
        j.rot_b12 = bounded_value(UNIT_BOUND);
        j.rot_b31 = bounded_value(UNIT_BOUND);
        j.rot_b23 = bounded_value(UNIT_BOUND);
      end
      default: ;
    endcase
    return j;
  endfunction

  // Drive one job; on acceptance queue its result (typed in or predicted).
  task automatic send_job(input rot_job_t job, input bit typed, input rot_res_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) source_calm = !source_calm;
    gap = source_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.vec_x   <= job.vec_x;
    in_if.vec_y   <= job.vec_y;
    in_if.vec_z   <= job.vec_z;
    in_if.rot_s   <= job.rot_s;
    in_if.rot_b12 <= job.rot_b12;
    in_if.rot_b31 <= job.rot_b31;
    in_if.rot_b23 <= job.rot_b23;
    do @(posedge clk_i); while (!in_if.ready);
    pending_rotations.push_back(typed ? want : predict_rotation(job));
  endtask

  initial begin : stimulus
    vector_case_t row;
    // Typed rows: zero input, identity rotor, half-turns about each plane,
    // scale by four with saturation, scale by one quarter for tie rounding.
    directed_cases = '{
      make_case(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0),
      make_case(32767, -32768, 0, 16384, 0, 0, 0, 1, 32767, -32768, 0, 0),
      make_case(1, -1, 12345, 16384, 0, 0, 0, 1, 1, -1, 12345, 0),
      make_case(-32768, 32767, -1, -16384, 0, 0, 0, 1, -32768, 32767, -1, 0),
      make_case(100, -200, 300, 0, 16384, 0, 0, 1, -100, 200, 300, 0),
      make_case(-32768, 0, 7, 0, 16384, 0, 0, 1, 32767, 0, 7, 1),
      make_case(100, -200, 300, 0, 0, 16384, 0, 1, -100, -200, -300, 0),
      make_case(100, -200, 300, 0, 0, 0, 16384, 1, 100, 200, -300, 0),
      make_case(32767, -32768, 1, -32768, 0, 0, 0, 1, 32767, -32768, 4, 1),
      make_case(2, -2, 1, 8192, 0, 0, 0, 1, 1, 0, 0, 0),
      make_case(-6, 6, -1, 8192, 0, 0, 0, 1, -1, 2, 0, 0),
      make_case(3, -3, 5, 8192, 0, 0, 0, 1, 1, -1, 1, 0),
      make_case(1, 2, 3, -32768, -32768, -32768, -32768, 1, 48, 16, 32, 0),
      // predicted rows: full-scale and unnormalized rotors, quarter turns
      make_case(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0),
      make_case(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0),
      make_case(1000, 0, 0, 11585, 11585, 0, 0, 0, 0, 0, 0, 0),
      make_case(0, 1000, -1000, 11585, 0, -11585, 0, 0, 0, 0, 0, 0),
      make_case(1234, -5678, 9012, 8192, 8192, 8192, 8192, 0, 0, 0, 0, 0),
      make_case(32767, -32768, 32767, 1, -1, 1, -1, 0, 0, 0, 0, 0),
      make_case(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0),
      make_case(21845, -21846, 21845, -21846, 21845, -21846, 21845, 0, 0, 0, 0, 0),
      make_case(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 0, 0, 0, 0, 0)
    };

    in_if.valid   <= 1'b0;
    in_if.vec_x   <= '0;
    in_if.vec_y   <= '0;
    in_if.vec_z   <= '0;
    in_if.rot_s   <= '0;
    in_if.rot_b12 <= '0;
    in_if.rot_b31 <= '0;
    in_if.rot_b23 <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      row = directed_cases[i];
      send_job(row.job, row.typed, row.res);
    end
    for (int n = 0; n < RANDOM_JOBS; n++) begin
      send_job(random_job(), 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_rotations.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Output side: stall a random number of cycles before taking each result.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin : result_check
    rot_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_rotations.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                  out_if.out_x, out_if.out_y, out_if.out_z));
      end else begin
        want = pending_rotations.pop_front();
        if (out_if.out_x !== want.out_x)
          report_mismatch($sformatf("out_x got %0d want %0d", out_if.out_x, want.out_x));
        if (out_if.out_y !== want.out_y)
          report_mismatch($sformatf("out_y got %0d want %0d", out_if.out_y, want.out_y));
        if (out_if.out_z !== want.out_z)
          report_mismatch($sformatf("out_z got %0d want %0d", out_if.out_z, want.out_z));
        if (out_if.clipped !== want.clipped)
          report_mismatch($sformatf("clipped got %0b want %0b",
                                    out_if.clipped, want.clipped));
      end
    end
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
